// ----- hw/rtl/pkft_pkg.sv -----
// Package for the pair keyed frequency table: sizes, item and result types,
// status codes and the command and status bundles between controller and datapath.
// No dependencies.
package pkft_pkg;

    // Table sizes and count width.
    localparam int MAX_DOCS    = 16;
    localparam int MAX_ENTRIES = 64;
    localparam int COUNT_BITS  = 16;

    // Index and fill count widths derived from the sizes.
    localparam int DOC_IDX_W = (MAX_DOCS > 1) ? $clog2(MAX_DOCS) : 1;
    localparam int DOC_CNT_W = $clog2(MAX_DOCS + 1);
    localparam int ENT_IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENT_CNT_W = $clog2(MAX_ENTRIES + 1);

    // Command codes of an input transaction.
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_DUMP = 1'b1;

    // Status codes of a result.
    localparam logic [2:0] ST_NEW   = 3'd0;
    localparam logic [2:0] ST_INC   = 3'd1;
    localparam logic [2:0] ST_DROP  = 3'd2;
    localparam logic [2:0] ST_ENTRY = 3'd3;
    localparam logic [2:0] ST_EMPTY = 3'd4;

    // Input transaction payload.
    typedef struct packed {
        logic        command;
        logic [15:0] doc_key;
        logic [19:0] word_key;
    } t_item;

    // Result transaction payload.
    typedef struct packed {
        logic [15:0] out_doc;
        logic [19:0] out_word;
        logic [15:0] out_count;
        logic [2:0]  status;
        logic        last;
    } t_result;

    // One stored pair with its count.
    typedef struct packed {
        logic [DOC_IDX_W-1:0]  slot;
        logic [19:0]           word;
        logic [COUNT_BITS-1:0] tally;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic doc_latch;
        logic add_init;
        logic dump_init;
        logic idx_inc;
        logic idx_dec;
        logic doc_dec;
        logic update;
        logic insert;
        logic drop;
        logic empty;
        logic dump_hit;
        logic flush;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_dump;
        logic doc_hit;
        logic entries_empty;
        logic word_match;
        logic dump_match;
        logic idx_last;
        logic idx_zero;
        logic dslot_zero;
        logic full;
    } t_dp_status;

endpackage

// ----- hw/rtl/pkft_ram.sv -----
// Generic simple dual port RAM with one write port and a registered read port.
// No dependencies.
module pkft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/pkft_ctrl.sv -----
// Controller state machine of the pair keyed frequency table.
// Depends on pkft_pkg for the command and status bundles.
module pkft_ctrl
    import pkft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_ARD,
        S_ACMP,
        S_DECIDE,
        S_DRD,
        S_DCMP,
        S_DFLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_dump) begin
                    if (i_status.entries_empty) begin
                        o_cmd.empty = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.dump_init = 1'b1;
                        n_state         = S_DRD;
                    end
                end else begin
                    o_cmd.doc_latch = 1'b1;
                    if (i_status.doc_hit && !i_status.entries_empty) begin
                        o_cmd.add_init = 1'b1;
                        n_state        = S_ARD;
                    end else begin
                        n_state = S_DECIDE;
                    end
                end
            end
            S_ARD: begin
                n_state = S_ACMP;
            end
            S_ACMP: begin
                if (i_status.word_match) begin
                    o_cmd.update = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_status.idx_last) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_ARD;
                end
            end
            S_DECIDE: begin
                if (i_status.full) begin
                    o_cmd.drop = 1'b1;
                end else begin
                    o_cmd.insert = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_DRD: begin
                n_state = S_DCMP;
            end
            S_DCMP: begin
                o_cmd.dump_hit = i_status.dump_match;
                if (!i_status.idx_zero) begin
                    o_cmd.idx_dec = 1'b1;
                    n_state       = S_DRD;
                end else if (!i_status.dslot_zero) begin
                    o_cmd.doc_dec = 1'b1;
                    n_state       = S_DRD;
                end else begin
                    n_state = S_DFLUSH;
                end
            end
            S_DFLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- hw/rtl/pkft_dpath.sv -----
// Datapath of the pair keyed frequency table: document key registers, fill counts,
// entry memory, scan indexes and the result register.
// Depends on pkft_pkg and pkft_ram.
module pkft_dpath
    import pkft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_item,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    output logic       o_valid,
    output t_result    o_result
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    t_item                r_item;
    logic [15:0]          r_doc_key [MAX_DOCS];
    logic [DOC_CNT_W-1:0] r_doc_used;
    logic [ENT_CNT_W-1:0] r_ent_used;
    logic                 r_doc_found;
    logic [DOC_IDX_W-1:0] r_slot;
    logic [ENT_IDX_W-1:0] r_idx;
    logic [DOC_IDX_W-1:0] r_dslot;
    t_result              r_pend;
    logic                 r_pend_v;
    t_result              r_res;
    logic                 r_valid;

    t_result              n_res;
    logic                 n_valid;
    t_result              dump_res;
    logic                 hit;
    logic [DOC_IDX_W-1:0] hit_slot;
    logic [COUNT_BITS-1:0] inc_tally;
    logic [DOC_IDX_W-1:0] ins_slot;

    logic                 ram_we;
    logic [ENT_IDX_W-1:0] ram_waddr;
    t_entry               ram_wdata;
    logic [$bits(t_entry)-1:0] ram_rdata;
    t_entry               rd_entry;

    // Entry memory, read continuously at the scan index.
    pkft_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);

    // Parallel document lookup over the slots in use; the first match wins.
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int s = 0; s < MAX_DOCS; s++) begin
            if (!hit && (DOC_CNT_W'(s) < r_doc_used) &&
                (r_doc_key[s] == r_item.doc_key)) begin
                hit      = 1'b1;
                hit_slot = DOC_IDX_W'(s);
            end
        end
    end

    // Status toward the controller.
    always_comb begin
        o_status.is_dump       = (r_item.command == CMD_DUMP);
        o_status.doc_hit       = hit;
        o_status.entries_empty = (r_ent_used == '0);
        o_status.word_match    = (rd_entry.slot == r_slot) &&
                                 (rd_entry.word == r_item.word_key);
        o_status.dump_match    = (rd_entry.slot == r_dslot);
        o_status.idx_last      = (ENT_CNT_W'(r_idx) == (r_ent_used - ENT_CNT_W'(1)));
        o_status.idx_zero      = (r_idx == '0);
        o_status.dslot_zero    = (r_dslot == '0);
        o_status.full          = (r_ent_used == ENT_CNT_W'(MAX_ENTRIES)) ||
                                 (!r_doc_found && (r_doc_used == DOC_CNT_W'(MAX_DOCS)));
    end

    // Saturating increment and the slot of an inserted pair.
    assign inc_tally = (rd_entry.tally == CNT_MAX) ? CNT_MAX
                                                   : rd_entry.tally + COUNT_BITS'(1);
    assign ins_slot  = r_doc_found ? r_slot : DOC_IDX_W'(r_doc_used);

    // Memory write for an update in place or an insert at the fill count.
    always_comb begin
        ram_we    = i_cmd.update || i_cmd.insert;
        ram_waddr = r_idx;
        ram_wdata = rd_entry;
        if (i_cmd.insert) begin
            ram_waddr       = ENT_IDX_W'(r_ent_used);
            ram_wdata.slot  = ins_slot;
            ram_wdata.word  = r_item.word_key;
            ram_wdata.tally = COUNT_BITS'(1);
        end else begin
            ram_wdata.tally = inc_tally;
        end
    end

    // Result of one matching entry during a dump.
    always_comb begin
        dump_res.out_doc   = r_doc_key[r_dslot];
        dump_res.out_word  = rd_entry.word;
        dump_res.out_count = 16'(rd_entry.tally);
        dump_res.status    = ST_ENTRY;
        dump_res.last      = 1'b0;
    end

    // Next result transaction.
    always_comb begin
        n_valid = 1'b0;
        n_res   = r_res;
        if (i_cmd.update) begin
            n_valid         = 1'b1;
            n_res.out_doc   = r_item.doc_key;
            n_res.out_word  = r_item.word_key;
            n_res.out_count = 16'(inc_tally);
            n_res.status    = ST_INC;
            n_res.last      = 1'b1;
        end else if (i_cmd.insert) begin
            n_valid         = 1'b1;
            n_res.out_doc   = r_item.doc_key;
            n_res.out_word  = r_item.word_key;
            n_res.out_count = 16'(COUNT_BITS'(1));
            n_res.status    = ST_NEW;
            n_res.last      = 1'b1;
        end else if (i_cmd.drop) begin
            n_valid         = 1'b1;
            n_res.out_doc   = r_item.doc_key;
            n_res.out_word  = r_item.word_key;
            n_res.out_count = '0;
            n_res.status    = ST_DROP;
            n_res.last      = 1'b1;
        end else if (i_cmd.empty) begin
            n_valid         = 1'b1;
            n_res.out_doc   = '0;
            n_res.out_word  = '0;
            n_res.out_count = '0;
            n_res.status    = ST_EMPTY;
            n_res.last      = 1'b1;
        end else if (i_cmd.dump_hit && r_pend_v) begin
            // A new match means the held entry is not the final one.
            n_valid = 1'b1;
            n_res   = r_pend;
        end else if (i_cmd.flush) begin
            n_valid    = 1'b1;
            n_res      = r_pend;
            n_res.last = 1'b1;
        end
    end

    // Control registers: fill counts and strobes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_used <= '0;
            r_ent_used <= '0;
            r_pend_v   <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= n_valid;
            if (i_cmd.insert) begin
                r_ent_used <= r_ent_used + ENT_CNT_W'(1);
                if (!r_doc_found) begin
                    r_doc_used <= r_doc_used + DOC_CNT_W'(1);
                end
            end
            if (i_cmd.dump_hit) begin
                r_pend_v <= 1'b1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Payload registers: captured transaction, lookup result, indexes, keys.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.doc_latch) begin
            r_doc_found <= hit;
            r_slot      <= hit_slot;
        end
        if (i_cmd.insert && !r_doc_found) begin
            r_doc_key[DOC_IDX_W'(r_doc_used)] <= r_item.doc_key;
        end
        if (i_cmd.dump_hit) begin
            r_pend <= dump_res;
        end
        // Scan index and document slot walk.
        if (i_cmd.add_init) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + ENT_IDX_W'(1);
        end else if (i_cmd.idx_dec) begin
            r_idx <= r_idx - ENT_IDX_W'(1);
        end else if (i_cmd.dump_init || i_cmd.doc_dec) begin
            r_idx <= ENT_IDX_W'(r_ent_used - ENT_CNT_W'(1));
        end
        if (i_cmd.dump_init) begin
            r_dslot <= DOC_IDX_W'(r_doc_used - DOC_CNT_W'(1));
        end else if (i_cmd.doc_dec) begin
            r_dslot <= r_dslot - DOC_IDX_W'(1);
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

// ----- hw/rtl/pair_keyed_frequency_table.sv -----
// Add: for a new document the decide state strobes the insert or its drop; for a known one,
// entries scan from index 0, a match strobes the update and a full miss goes to decide.
// Dump: one strobe per entry, the final one flagged last, walking slots and entries downward,
// each entry memory read followed by a compare; an empty table gives its single result.
// The next transaction is accepted on the edge after the final result is registered.
// Reset clears the fill counts, no clearing pass follows; the receiver cannot stall.
module pair_keyed_frequency_table
    import pkft_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_valid,
    output t_result o_result
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // Controller sequences lookups, scans and dumps.
    pkft_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath holds the tables and forms each result transaction.
    pkft_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule
